// ===== rtl/pbgu_pkg.sv =====
// Package for the periodic bilinear grid upsampler.
// Holds the fixed field widths, command codes and coordinate map types.
// No dependencies.
`timescale 1ns / 1ps

package pbgu_pkg;

    localparam int PT_W   = 3;
    localparam int MESH_W = 6;
    localparam int MESH_N = 64;
    localparam int VAL_W  = 16;
    localparam int CRD_W  = 6;
    localparam int FRC_W  = 6;

    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_READ  = 1'b1
    } t_cmd;

    typedef struct packed {
        logic [CRD_W-1:0] c;
        logic [CRD_W-1:0] n;
        logic [FRC_W-1:0] f;
    } t_crd_map;

    typedef t_crd_map [MESH_N-1:0] t_map_tab;

endpackage

// ===== rtl/pbgu_floor_div.sv =====
// Floored division of the interpolation sum by SCALE squared, saturated to 16 bits.
// Uses a constant reciprocal multiply and an exact remainder check.
// Depends on pbgu_pkg.
`timescale 1ns / 1ps

module pbgu_floor_div
    import pbgu_pkg::*;
#(
    parameter int ACC_W = 30,
    parameter int SCALE = 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [ACC_W-1:0] i_num,
    output logic                    o_done,
    output logic signed [VAL_W-1:0] o_quot
);

    localparam int DEN   = SCALE * SCALE;
    localparam int DEN_L = $clog2(DEN);
    localparam int MAG_W = DEN_L + VAL_W - 1;
    localparam int SHIFT = MAG_W + DEN_L;
    localparam int RCP_W = MAG_W + 2;
    localparam int PRD_W = MAG_W + RCP_W;
    localparam int CMP_W = (ACC_W > MAG_W + 1) ? ACC_W : MAG_W + 1;
    localparam logic [CMP_W-1:0] DEN_TOP  = CMP_W'(DEN * 32768);
    localparam logic [CMP_W-1:0] DEN_C    = CMP_W'(DEN);
    localparam logic [63:0]      RCP_FULL = ((64'd1 << SHIFT) + 64'(DEN) - 64'd1) / 64'(DEN);
    localparam logic [RCP_W-1:0] RCP      = RCP_FULL[RCP_W-1:0];

    typedef enum logic [1:0] {
        D_IDLE,
        D_CHECK,
        D_FIX
    } t_dstate;

    t_dstate            r_state;
    logic               r_neg;
    logic [CMP_W-1:0]   r_mag;
    logic [PRD_W-1:0]   r_prd;
    logic               r_done;
    logic signed [VAL_W-1:0] r_quot;

    logic [ACC_W-1:0]   num_mag;
    logic [VAL_W-1:0]   quo;
    logic [CMP_W-1:0]   back;
    logic signed [VAL_W:0] q_ext;
    logic signed [VAL_W:0] q_fix;

    assign num_mag = i_num[ACC_W-1] ? ACC_W'(-i_num) : ACC_W'(i_num);
    assign quo     = r_prd[SHIFT +: VAL_W];
    assign back    = CMP_W'(quo) * DEN_C;
    assign q_ext   = signed'({1'b0, quo});
    assign q_fix   = r_neg ? (-q_ext - ((r_mag != back) ? 17'sd1 : 17'sd0)) : q_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                D_IDLE: begin
                    if (i_start) begin
                        r_neg   <= i_num[ACC_W-1];
                        r_mag   <= CMP_W'(num_mag);
                        r_state <= D_CHECK;
                    end
                end
                D_CHECK: begin
                    r_prd <= PRD_W'(r_mag[MAG_W-1:0]) * PRD_W'(RCP);
                    if (r_mag >= DEN_TOP) begin
                        r_quot  <= r_neg ? 16'sh8000 : 16'sh7FFF;
                        r_done  <= 1'b1;
                        r_state <= D_IDLE;
                    end else begin
                        r_state <= D_FIX;
                    end
                end
                D_FIX: begin
                    r_quot  <= q_fix[VAL_W-1:0];
                    r_done  <= 1'b1;
                    r_state <= D_IDLE;
                end
                default: begin
                    r_state <= D_IDLE;
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ===== rtl/periodic_bilinear_grid_upsampler.sv =====
// Top level of the periodic bilinear grid upsampler: sample memory, sequencer and MAC.
// Depends on pbgu_pkg and pbgu_floor_div.
//
// Usage. An item is taken at a rising edge with start high and busy low.
// A write beat (command CMD_WRITE) stores sample_value at (sample_col, sample_row)
// when both lie inside the grid; its acknowledge appears on the result ports in
// the next cycle with o_is_read_result low and o_value zero. busy stays low, so
// writes can follow one per cycle.
// A read beat (command CMD_READ) names a fine mesh point. The four surrounding
// coarse samples are read one per cycle from the single memory port and summed
// with their bilinear weights, then divided by SCALE squared with a constant
// reciprocal multiply and a remainder check. The result follows the MAC steps and the
// divider check and fix states (no fix if saturated); busy falls as it appears.
// Each result is held for exactly one cycle, marked by o_result_strobe, and the
// receiver must take it then. Reset clears the sequencer and the strobe; the
// sample memory is not cleared and must be written before it is read.
`timescale 1ns / 1ps

module periodic_bilinear_grid_upsampler
    import pbgu_pkg::*;
#(
    parameter int SAMPLE_POINTS = 8,
    parameter int SCALE         = 8,
    parameter int MESH_SIZE     = 64,
    parameter int SAMPLE_WIDTH  = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic                    i_command,
    input  logic [PT_W-1:0]         i_sample_col,
    input  logic [PT_W-1:0]         i_sample_row,
    input  logic signed [VAL_W-1:0] i_sample_value,
    input  logic [MESH_W-1:0]       i_mesh_col,
    input  logic [MESH_W-1:0]       i_mesh_row,
    output logic                    o_result_strobe,
    output logic                    o_is_read_result,
    output logic signed [VAL_W-1:0] o_value
);

    localparam int DEPTH  = SAMPLE_POINTS * SAMPLE_POINTS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int WX_W   = $clog2(SCALE + 1);
    localparam int WGT_W  = 2 * WX_W;
    localparam int ACC_W  = SAMPLE_WIDTH + WGT_W + 1;

    function automatic t_map_tab build_map();
        t_map_tab tab;
        int m;
        int f;
        int c;
        m = 0;
        f = 0;
        c = 0;
        for (int v = 0; v < MESH_N; v++) begin
            tab[v].c = CRD_W'(c);
            tab[v].n = CRD_W'((c + 1 == SAMPLE_POINTS) ? 0 : c + 1);
            tab[v].f = FRC_W'(f);
            m++;
            f++;
            if (f == SCALE) begin
                f = 0;
                c++;
                if (c == SAMPLE_POINTS) begin
                    c = 0;
                end
            end
            if (m == MESH_SIZE) begin
                m = 0;
                f = 0;
                c = 0;
            end
        end
        return tab;
    endfunction

    localparam t_map_tab MESH_MAP = build_map();

    function automatic logic [ADDR_W-1:0] addr_of(input logic [CRD_W-1:0] col,
                                                  input logic [CRD_W-1:0] row);
        return ADDR_W'(int'(row) * SAMPLE_POINTS + int'(col));
    endfunction

    typedef enum logic [1:0] {
        S_IDLE,
        S_MAC,
        S_DIV
    } t_state;

    t_state                    r_state;
    logic [2:0]                r_step;
    logic [CRD_W-1:0]          r_cx;
    logic [CRD_W-1:0]          r_nx;
    logic [FRC_W-1:0]          r_fx;
    logic [CRD_W-1:0]          r_cy;
    logic [CRD_W-1:0]          r_ny;
    logic [FRC_W-1:0]          r_fy;
    logic [WGT_W-1:0]          r_wgt;
    logic signed [ACC_W-1:0]   r_acc;
    logic                      r_div_go;
    logic                      r_strobe;
    logic                      r_is_rd;
    logic signed [VAL_W-1:0]   r_value;

    logic signed [SAMPLE_WIDTH-1:0] mem [DEPTH];
    logic signed [SAMPLE_WIDTH-1:0] r_rdata;

    t_crd_map                  map_x;
    t_crd_map                  map_y;
    logic                      accept;
    logic                      wr_en;
    logic [ADDR_W-1:0]         wr_addr;
    logic [ADDR_W-1:0]         rd_addr;
    logic signed [31:0]        wr_ext;
    logic signed [SAMPLE_WIDTH-1:0] wr_data;
    logic [WX_W-1:0]           wx;
    logic [WX_W-1:0]           wy;
    logic signed [WGT_W:0]     wgt_s;
    logic signed [ACC_W-1:0]   prod;
    logic                      div_done;
    logic signed [VAL_W-1:0]   div_quot;

    assign busy    = (r_state != S_IDLE);
    assign accept  = start && !busy;
    assign map_x   = MESH_MAP[i_mesh_col];
    assign map_y   = MESH_MAP[i_mesh_row];

    assign wr_en   = accept && (i_command == CMD_WRITE)
                     && (int'(i_sample_col) < SAMPLE_POINTS)
                     && (int'(i_sample_row) < SAMPLE_POINTS);
    assign wr_addr = addr_of(CRD_W'(i_sample_col), CRD_W'(i_sample_row));
    assign wr_ext  = 32'(i_sample_value);
    assign wr_data = wr_ext[SAMPLE_WIDTH-1:0];

    assign rd_addr = addr_of(r_step[0] ? r_nx : r_cx, r_step[1] ? r_ny : r_cy);
    assign wx      = r_step[0] ? WX_W'(r_fx) : WX_W'(SCALE) - WX_W'(r_fx);
    assign wy      = r_step[1] ? WX_W'(r_fy) : WX_W'(SCALE) - WX_W'(r_fy);
    assign wgt_s   = signed'({1'b0, r_wgt});
    assign prod    = ACC_W'(r_rdata) * ACC_W'(wgt_s);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end else begin
            r_rdata <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_step   <= '0;
            r_div_go <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            r_div_go <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (i_command == CMD_WRITE) begin
                            r_strobe <= 1'b1;
                            r_is_rd  <= 1'b0;
                            r_value  <= '0;
                        end else begin
                            r_cx    <= map_x.c;
                            r_nx    <= map_x.n;
                            r_fx    <= map_x.f;
                            r_cy    <= map_y.c;
                            r_ny    <= map_y.n;
                            r_fy    <= map_y.f;
                            r_acc   <= '0;
                            r_step  <= '0;
                            r_state <= S_MAC;
                        end
                    end
                end
                S_MAC: begin
                    r_wgt  <= WGT_W'(wx) * WGT_W'(wy);
                    r_step <= r_step + 3'd1;
                    if (r_step != 3'd0) begin
                        r_acc <= r_acc + prod;
                    end
                    if (r_step == 3'd4) begin
                        r_div_go <= 1'b1;
                        r_state  <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_strobe <= 1'b1;
                        r_is_rd  <= 1'b1;
                        r_value  <= div_quot;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    pbgu_floor_div #(
        .ACC_W (ACC_W),
        .SCALE (SCALE)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_go),
        .i_num   (r_acc),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign o_result_strobe  = r_strobe;
    assign o_is_read_result = r_is_rd;
    assign o_value          = r_value;

endmodule
